### design/bmftl_pkg.sv
// ---------------------------------------------------------------------------
// bmftl_pkg: shared types and codes for the block-mapped flash sequencer.
// Holds the request kinds, the output operation codes and the map fill value.
// ---------------------------------------------------------------------------
package bmftl_pkg;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_MAP    = 2'd2,
    REQ_FREE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_ERASE   = 3'd0,
    OP_READ    = 3'd1,
    OP_PROGRAM = 3'd2,
    OP_TO_HOST = 3'd3,
    OP_FROM_HOST = 3'd4
  } op_e;

  localparam logic [15:0] UNMAPPED = 16'hFFFF;

endpackage

### design/block_mapped_ftl_sequencer.sv
// ---------------------------------------------------------------------------
// block_mapped_ftl_sequencer: block-mapped flash translation sequencer.
// Splits each chunk's address into block, page and sector, and emits the
// erase, read, program and transfer operations for it.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          fields
//  request   in         start & !busy      req_type_i, lba_i, remaining_sectors_i,
//                                          first_chunk_i, table_index_i,
//                                          table_value_i
//  result    out        valid_o (1 cycle)  op_o, phys_block_o, page_index_o,
//                                          buffer_offset_o, transfer_len_o, last_o
//
// After reset a clearing pass writes the map to all ones, one entry a cycle,
// with busy high. A map or free load is written as it is accepted.
// A read emits a flash read, then a host transfer. A write emits one result a
// cycle, besides the take, the two memory reads and, last, the closing update.
// The receiver cannot stall; results go out as produced.
module block_mapped_ftl_sequencer
  import bmftl_pkg::*;
#(
  parameter int LOGICAL_BLOCKS   = 8192,
  parameter int FREE_SLOTS       = 2048,
  parameter int PAGES_PER_BLOCK  = 16,
  parameter int SECTORS_PER_PAGE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [21:0] lba_i,
  input  logic [15:0] remaining_sectors_i,
  input  logic        first_chunk_i,
  input  logic [12:0] table_index_i,
  input  logic [15:0] table_value_i,
  output logic        valid_o,
  output logic [2:0]  op_o,
  output logic [15:0] phys_block_o,
  output logic [3:0]  page_index_o,
  output logic [7:0]  buffer_offset_o,
  output logic [5:0]  transfer_len_o,
  output logic        last_o
);

  localparam int LbW    = $clog2(LOGICAL_BLOCKS);
  localparam int FsW    = $clog2(FREE_SLOTS);
  localparam int PgW    = $clog2(PAGES_PER_BLOCK);
  localparam int RowSec = 2 * SECTORS_PER_PAGE;
  localparam int SecW   = $clog2(RowSec);
  localparam int FreeCap = (FREE_SLOTS > 4095) ? 4095 : FREE_SLOTS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_LOOK, S_RD_EMIT, S_WR_TAKE, S_WR_FREE, S_WR_MAP, S_WR_MAPD,
    S_WR_HEAD, S_WR_MID, S_WR_TAIL, S_WR_FINISH, S_WR_CROSS
  } state_e;

  state_e state_q;
  logic [LbW-1:0]  clr_q;
  logic [1:0]      step_q;
  logic [PgW:0]    pg_q;     // running page for head and tail copies
  logic            half_q;   // 0 read, 1 program within a copy pair
  logic [11:0]     free_count_q, take_index_q, return_slot_q;
  logic [15:0]     cur_user_q, cur_free_q;
  logic            first_q, is_last_q;
  logic [LbW-1:0]  lb_q;
  logic [PgW-1:0]  page_q;
  logic [7:0]      off_q;
  logic [5:0]      len_q;

  // Address split of the incoming request.
  logic [21-SecW:0] row_w;
  logic [SecW-1:0]  sect_w;
  logic [PgW-1:0]   page_w;
  logic [LbW-1:0]   lb_w;
  logic [SecW:0]    room_w;
  assign row_w  = lba_i[21:SecW];
  assign sect_w = lba_i[SecW-1:0];
  assign page_w = row_w[PgW-1:0];
  assign lb_w   = LbW'(row_w >> PgW);
  assign room_w = (SecW+1)'(RowSec) - {1'b0, sect_w};

  // Memory ports.
  logic            map_we, fr_we;
  logic [LbW-1:0]  map_addr;
  logic [FsW-1:0]  fr_addr;
  logic [15:0]     map_wdata, fr_wdata, map_rdata, fr_rdata;

  bmftl_ram #(.Width(16), .Depth(LOGICAL_BLOCKS)) u_map (
    .clk_i(clk_i), .we_i(map_we), .addr_i(map_addr), .wdata_i(map_wdata),
    .rdata_o(map_rdata)
  );
  bmftl_ram #(.Width(16), .Depth(FREE_SLOTS)) u_free (
    .clk_i(clk_i), .we_i(fr_we), .addr_i(fr_addr), .wdata_i(fr_wdata),
    .rdata_o(fr_rdata)
  );

  logic [11:0] take_next;
  always_comb begin
    take_next = take_index_q + 12'd1;
    if (take_next >= free_count_q) take_next = '0;
  end

  logic [LbW-1:0] prev_lb;
  assign prev_lb = lb_q - LbW'(1);
  logic in_range_ret;
  assign in_range_ret = {1'b0, return_slot_q} < 13'(FREE_SLOTS);
  logic in_range_take;
  assign in_range_take = {1'b0, take_index_q} < 13'(FREE_SLOTS);

  assign busy = (state_q != S_IDLE);
  logic accept;
  assign accept = start && !busy;

  always_comb begin
    map_we = 1'b0; map_addr = lb_q; map_wdata = cur_free_q;
    fr_we = 1'b0; fr_addr = FsW'(take_next); fr_wdata = cur_user_q;
    case (state_q)
      S_CLEAR: begin map_we = 1'b1; map_addr = clr_q; map_wdata = UNMAPPED; end
      S_IDLE: begin
        map_addr = lb_w;
        if (accept && req_type_i == REQ_MAP && 32'(table_index_i) < LOGICAL_BLOCKS) begin
          map_we = 1'b1; map_addr = LbW'(table_index_i); map_wdata = table_value_i;
        end
        if (accept && req_type_i == REQ_FREE && free_count_q < 12'(FreeCap)) begin
          fr_we = 1'b1; fr_addr = FsW'(free_count_q); fr_wdata = table_value_i;
        end
      end
      S_WR_CROSS: begin
        map_we = 1'b1; map_addr = prev_lb;
        fr_we = in_range_ret; fr_addr = FsW'(return_slot_q);
      end
      S_WR_FINISH: begin
        map_we = 1'b1;
        fr_we = in_range_ret; fr_addr = FsW'(return_slot_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; valid_o <= 1'b0;
      free_count_q <= '0; take_index_q <= '0; return_slot_q <= '0;
      cur_user_q <= '0; cur_free_q <= '0; pg_q <= '0; half_q <= 1'b0; step_q <= '0;
      first_q <= 1'b0; is_last_q <= 1'b0; lb_q <= '0; page_q <= '0;
      off_q <= '0; len_q <= '0;
      op_o <= OP_ERASE; phys_block_o <= '0; page_index_o <= '0;
      buffer_offset_o <= '0; transfer_len_o <= '0; last_o <= 1'b0;
    end else begin
      valid_o <= 1'b0; last_o <= 1'b0;
      op_o <= OP_ERASE; phys_block_o <= '0; page_index_o <= '0;
      buffer_offset_o <= '0; transfer_len_o <= '0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + LbW'(1);
          if (32'(clr_q) == LOGICAL_BLOCKS - 1) state_q <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          first_q <= first_chunk_i;
          lb_q <= lb_w; page_q <= page_w;
          off_q <= (32'(sect_w) >= SECTORS_PER_PAGE)
                 ? 8'(32'(sect_w) + 7 * SECTORS_PER_PAGE) : 8'(sect_w);
          len_q <= (17'(room_w) > 17'(remaining_sectors_i))
                 ? 6'(remaining_sectors_i) : 6'(room_w);
          is_last_q <= 17'(remaining_sectors_i) <= 17'(room_w);
          case (req_type_i)
            REQ_READ: state_q <= S_RD_LOOK;
            REQ_WRITE: begin
              if (first_chunk_i) state_q <= S_WR_TAKE;
              else if (page_w == '0 && sect_w == '0) state_q <= S_WR_CROSS;
              else state_q <= S_WR_MAP;
            end
            REQ_FREE: if (free_count_q < 12'(FreeCap)) begin
              free_count_q <= free_count_q + 12'd1;
              take_index_q <= free_count_q + 12'd1;
              return_slot_q <= free_count_q + 12'd1;
            end
            default: ;
          endcase
        end
        S_RD_LOOK: state_q <= S_RD_EMIT;  // map read data lands here
        S_RD_EMIT: begin
          valid_o <= 1'b1;
          if (step_q == 2'd0) begin
            op_o <= OP_READ; phys_block_o <= map_rdata; page_index_o <= 4'(page_q);
            step_q <= 2'd1;
          end else begin
            op_o <= OP_TO_HOST; buffer_offset_o <= off_q; transfer_len_o <= len_q;
            last_o <= 1'b1; step_q <= '0; state_q <= S_IDLE;
          end
        end
        S_WR_CROSS: begin
          // Old mapping closed; now take a fresh block.
          state_q <= S_WR_TAKE;
        end
        S_WR_TAKE: begin
          take_index_q <= take_next; return_slot_q <= take_next;
          state_q <= S_WR_FREE;
        end
        S_WR_FREE: begin
          // Free memory was read at take_next during the take cycle.
          cur_free_q <= in_range_take ? fr_rdata : 16'd0;
          valid_o <= 1'b1; op_o <= OP_ERASE;
          phys_block_o <= in_range_take ? fr_rdata : 16'd0;
          state_q <= S_WR_MAP;
        end
        S_WR_MAP: state_q <= S_WR_MAPD;
        S_WR_MAPD: begin
          cur_user_q <= map_rdata; pg_q <= '0; half_q <= 1'b0; step_q <= '0;
          state_q <= (first_q && page_q != '0) ? S_WR_HEAD : S_WR_MID;
        end
        S_WR_HEAD: begin
          valid_o <= 1'b1; page_index_o <= 4'(pg_q);
          if (!half_q) begin
            op_o <= OP_READ; phys_block_o <= cur_user_q; half_q <= 1'b1;
          end else begin
            op_o <= OP_PROGRAM; phys_block_o <= cur_free_q; half_q <= 1'b0;
            pg_q <= pg_q + (PgW+1)'(1);
            if (pg_q + (PgW+1)'(1) == {1'b0, page_q}) state_q <= S_WR_MID;
          end
        end
        S_WR_MID: begin
          valid_o <= 1'b1;
          case (step_q)
            2'd0: begin
              op_o <= OP_READ; phys_block_o <= cur_user_q; page_index_o <= 4'(page_q);
              step_q <= 2'd1;
            end
            2'd1: begin
              op_o <= OP_FROM_HOST; buffer_offset_o <= off_q; transfer_len_o <= len_q;
              step_q <= 2'd2;
            end
            default: begin
              op_o <= OP_PROGRAM; phys_block_o <= cur_free_q; page_index_o <= 4'(page_q);
              step_q <= '0;
              pg_q <= {1'b0, page_q} + (PgW+1)'(1); half_q <= 1'b0;
              if (!is_last_q) begin
                last_o <= 1'b1; state_q <= S_IDLE;
              end else if (32'(page_q) == PAGES_PER_BLOCK - 1) begin
                last_o <= 1'b1; state_q <= S_WR_FINISH;
              end else begin
                state_q <= S_WR_TAIL;
              end
            end
          endcase
        end
        S_WR_TAIL: begin
          valid_o <= 1'b1; page_index_o <= 4'(pg_q);
          if (!half_q) begin
            op_o <= OP_READ; phys_block_o <= cur_user_q; half_q <= 1'b1;
          end else begin
            op_o <= OP_PROGRAM; phys_block_o <= cur_free_q; half_q <= 1'b0;
            pg_q <= pg_q + (PgW+1)'(1);
            if (32'(pg_q) == PAGES_PER_BLOCK - 1) begin
              last_o <= 1'b1; state_q <= S_WR_FINISH;
            end
          end
        end
        S_WR_FINISH: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A result strobe only comes out of an emitting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == S_RD_EMIT || $past(state_q) == S_WR_FREE ||
                 $past(state_q) == S_WR_HEAD || $past(state_q) == S_WR_MID ||
                 $past(state_q) == S_WR_TAIL))
    else $error("result strobe outside an emitting state");
  // The take pointer stays inside the filled part of the free list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_FREE && free_count_q != '0) |-> take_index_q < free_count_q)
    else $error("take pointer beyond free count");
  // The map is never written by a request while the clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> map_wdata == UNMAPPED)
    else $error("map written during clear");

endmodule

### design/bmftl_ram.sv
// ---------------------------------------------------------------------------
// bmftl_ram: generic single-port RAM with a registered read.
// One access per cycle; a write also returns the old data at its address.
// ---------------------------------------------------------------------------
module bmftl_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### tb/tb_block_mapped_ftl_sequencer.sv
// ---------------------------------------------------------------------------
// tb_block_mapped_ftl_sequencer: self-checking bench for the flash sequencer.
// Drives read, write, map-load and free-load requests and predicts every
// flash and transfer operation with its own copy of the map and free list.
// A scoreboard compares each strobed result with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_mapped_ftl_sequencer;
  import bmftl_pkg::*;

  localparam int LogicalBlocks = 8192;
  localparam int FreeSlots     = 2048;
  localparam int Pages         = 16;
  localparam int SectPage      = 16;
  localparam int RowSect       = 2 * SectPage;
  localparam int CycleLimit    = 400000;

  typedef struct {
    req_e        kind;
    logic [21:0] lba;
    logic [15:0] remain;
    logic        first;
    logic [12:0] tidx;
    logic [15:0] tval;
  } flash_req_t;

  typedef struct {
    op_e         op;
    logic [15:0] blk;
    logic [3:0]  page;
    logic [7:0]  off;
    logic [5:0]  len;
    logic        last;
  } flash_op_t;

  class ftl_scoreboard;
    logic [15:0] map_tab [LogicalBlocks];
    logic [15:0] free_tab [FreeSlots];
    int unsigned free_cnt, take_idx, ret_slot, user_blk, fresh_blk;
    flash_op_t   pending_ops [$];
    int          mismatches;
    int          n_ops;

    function new();
      foreach (map_tab[i]) map_tab[i] = UNMAPPED;
      foreach (free_tab[i]) free_tab[i] = '0;
      free_cnt = 0; take_idx = 0; ret_slot = 0; user_blk = 0; fresh_blk = 0;
      mismatches = 0;
    endfunction

    function void add_op(op_e op, int unsigned blk, int unsigned page,
                         int unsigned off, int unsigned len);
      flash_op_t o;
      o.op = op; o.blk = blk[15:0]; o.page = page[3:0];
      o.off = off[7:0]; o.len = len[5:0]; o.last = 1'b0;
      pending_ops.push_back(o);
      n_ops++;
    endfunction

    function int unsigned take_block();
      take_idx = (take_idx + 1) & 12'hFFF;
      if (take_idx >= free_cnt) take_idx = 0;
      ret_slot = take_idx;
      return (take_idx < FreeSlots) ? free_tab[take_idx] : 0;
    endfunction

    function void return_block(int unsigned blk);
      if (ret_slot < FreeSlots) free_tab[ret_slot] = blk[15:0];
    endfunction

    function void note_request(flash_req_t r);
      int unsigned row, sect, page, lb, off, len, prev;
      n_ops = 0;
      if (r.kind == REQ_MAP) begin
        map_tab[r.tidx] = r.tval;
        return;
      end
      if (r.kind == REQ_FREE) begin
        if (free_cnt < FreeSlots) begin
          free_tab[free_cnt] = r.tval;
          free_cnt++;
          take_idx = free_cnt;
          ret_slot = free_cnt;
        end
        return;
      end
      row  = r.lba / RowSect;
      sect = r.lba % RowSect;
      page = row % Pages;
      lb   = (row / Pages) % LogicalBlocks;
      off  = (sect >= SectPage) ? sect + 7 * SectPage : sect;
      len  = RowSect - sect;
      if (len > r.remain) len = r.remain;
      if (r.kind == REQ_READ) begin
        add_op(OP_READ, map_tab[lb], page, 0, 0);
        add_op(OP_TO_HOST, 0, 0, off, len);
      end else begin
        if (r.first) begin
          fresh_blk = take_block();
          add_op(OP_ERASE, fresh_blk, 0, 0, 0);
          user_blk = map_tab[lb];
          for (int i = 0; i < page; i++) begin
            add_op(OP_READ, user_blk, i, 0, 0);
            add_op(OP_PROGRAM, fresh_blk, i, 0, 0);
          end
        end else if (page == 0 && sect == 0) begin
          // Crossed into the next logical block: retire the previous one.
          prev = (lb == 0) ? LogicalBlocks - 1 : lb - 1;
          map_tab[prev] = fresh_blk[15:0];
          return_block(user_blk);
          fresh_blk = take_block();
          add_op(OP_ERASE, fresh_blk, 0, 0, 0);
        end
        user_blk = map_tab[lb];
        add_op(OP_READ, user_blk, page, 0, 0);
        add_op(OP_FROM_HOST, 0, 0, off, len);
        add_op(OP_PROGRAM, fresh_blk, page, 0, 0);
        if (r.remain <= RowSect - sect) begin
          for (int i = page + 1; i < Pages; i++) begin
            add_op(OP_READ, user_blk, i, 0, 0);
            add_op(OP_PROGRAM, fresh_blk, i, 0, 0);
          end
          map_tab[lb] = fresh_blk[15:0];
          return_block(user_blk);
        end
      end
      if (n_ops > 0) pending_ops[$].last = 1'b1;
    endfunction

    function void check_op(flash_op_t got);
      flash_op_t want;
      if (pending_ops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result op=%0d blk=%0h", got.op, got.blk);
        return;
      end
      want = pending_ops.pop_front();
      if (got.op !== want.op || got.blk !== want.blk || got.page !== want.page ||
          got.off !== want.off || got.len !== want.len || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp op=%0d blk=%0h pg=%0d off=%0d len=%0d last=%0b",
                    " got op=%0d blk=%0h pg=%0d off=%0d len=%0d last=%0b"},
                   want.op, want.blk, want.page, want.off, want.len, want.last,
                   got.op, got.blk, got.page, got.off, got.len, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [21:0] lba_i = '0;
  logic [15:0] remaining_sectors_i = '0;
  logic        first_chunk_i = 1'b0;
  logic [12:0] table_index_i = '0;
  logic [15:0] table_value_i = '0;
  logic        valid_o;
  logic [2:0]  op_o;
  logic [15:0] phys_block_o;
  logic [3:0]  page_index_o;
  logic [7:0]  buffer_offset_o;
  logic [5:0]  transfer_len_o;
  logic        last_o;

  ftl_scoreboard sb = new();
  int          idle_pct;
  int          n_sent;
  int          cycles;

  block_mapped_ftl_sequencer i_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_block_mapped_ftl_sequencer failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    flash_op_t got;
    if (rst_ni && valid_o) begin
      got.op = op_e'(op_o); got.blk = phys_block_o; got.page = page_index_o;
      got.off = buffer_offset_o; got.len = transfer_len_o; got.last = last_o;
      sb.check_op(got);
    end
  end

  // Called just after a rising edge; returns just after the edge that took the request, or after a random idle gap.
  task automatic send(flash_req_t r);
    req_type_i <= r.kind;
    lba_i <= r.lba;
    remaining_sectors_i <= r.remain;
    first_chunk_i <= r.first;
    table_index_i <= r.tidx;
    table_value_i <= r.tval;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    n_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_table(req_e kind, logic [12:0] idx, logic [15:0] val);
    flash_req_t r;
    r.kind = kind; r.lba = 22'($urandom); r.remain = 16'($urandom);
    r.first = 1'($urandom);
    r.tidx = idx; r.tval = val;
    send(r);
  endtask

  // Splits a host command into row-sized chunks the way firmware would.
  task automatic send_command(req_e kind, logic [21:0] lba, int unsigned count);
    flash_req_t r;
    int unsigned len;
    r.kind = kind; r.lba = lba; r.remain = count[15:0]; r.first = 1'b1;
    while (r.remain != 0) begin
      r.tidx = 13'($urandom); r.tval = 16'($urandom);
      if (kind == REQ_READ) r.first = 1'($urandom);
      len = RowSect - (r.lba % RowSect);
      if (len > r.remain) len = r.remain;
      send(r);
      r.lba = r.lba + len[21:0];
      r.remain = r.remain - len[15:0];
      r.first = 1'b0;
    end
  endtask

  task automatic send_noise();
    flash_req_t r;
    r.kind = ($urandom_range(1) == 0) ? REQ_READ : REQ_WRITE;
    r.lba = 22'($urandom); r.remain = 16'($urandom); r.first = 1'($urandom);
    r.tidx = 13'($urandom); r.tval = 16'($urandom);
    if ($urandom_range(3) == 0) r.remain = 16'($urandom_range(0, 40));
    send(r);
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned pick;
    logic [21:0] base;
    while (n_sent < target) begin
      pick = $urandom_range(99);
      base = 22'($urandom);
      if ($urandom_range(1) == 0) base = base & 22'h3F_FE00 | 22'(32 * $urandom_range(15));
      if (pick < 40) send_command(REQ_WRITE, base, $urandom_range(1, 90));
      else if (pick < 65) send_command(REQ_READ, base, $urandom_range(1, 70));
      else if (pick < 78) send_table(REQ_MAP, 13'($urandom), 16'($urandom));
      else if (pick < 88) send_table(REQ_FREE, 13'($urandom), 16'($urandom));
      else send_noise();
    end
  endtask

  initial begin
    flash_req_t r;
    idle_pct = 24;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The free list must hold an entry before any write takes a block.
    send_table(REQ_FREE, 13'd0, 16'h0000);
    send_table(REQ_FREE, 13'h1FFF, 16'hFFFF);
    send_table(REQ_FREE, 13'($urandom), 16'($urandom));
    send_table(REQ_MAP, 13'd0, 16'h0000);
    send_table(REQ_MAP, 13'h1FFF, 16'hFFFF);
    send_command(REQ_READ, 22'd0, 1);
    send_command(REQ_READ, 22'h3F_FFFF, 1);
    send_command(REQ_READ, 22'd20, 65535 - 65535 + 12);
    r.kind = REQ_READ; r.lba = 22'h3F_FFE0; r.remain = 16'hFFFF; r.first = 1'b1;
    r.tidx = '0; r.tval = '0;
    send(r);
    send_command(REQ_WRITE, 22'd0, 5);
    // First chunk on the last page: head copies of every other page.
    send_command(REQ_WRITE, 22'd480, 32);
    // Runs from the last page into the next block.
    send_command(REQ_WRITE, 22'd992, 64);
    send_command(REQ_WRITE, 22'h3F_FFF0, 16);
    send_command(REQ_WRITE, 22'd1040, 40);
    r.kind = REQ_WRITE; r.lba = 22'd77; r.remain = 16'd0; r.first = 1'b1;
    send(r);
    r.first = 1'b0; r.remain = 16'hFFFF;
    send(r);
    send_command(REQ_READ, 22'd0, 64);

    random_phase(110);
    idle_pct = 52;
    random_phase(180);
    idle_pct = 0;
    random_phase(225);

    // A few closing write commands with no gaps between requests.
    for (int i = 0; i < 3; i++)
      send_command(REQ_WRITE, 22'($urandom), $urandom_range(1, 70));
    start <= 1'b0;

    while (sb.pending_ops.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_ops.size() == 0) begin
      $display("tb_block_mapped_ftl_sequencer passed");
    end else begin
      $display("tb_block_mapped_ftl_sequencer failed");
    end
    $finish;
  end

endmodule
